// ===== hw/rtl/mrpt_pkg.sv =====
package mrpt_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned RgbW        = 3 * ChanW;
  localparam int unsigned ProdW       = 2 * ChanW;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned PaletteSize = 133;

  // Register map of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgHeadIdx = 2'd0,
    CfgBodyIdx = 2'd1,
    CfgLegsIdx = 2'd2,
    CfgFeetIdx = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    RegionNone,
    RegionHead,
    RegionBody,
    RegionLegs,
    RegionFeet
  } region_e;

  typedef struct packed {
    logic [ChanW-1:0] base_red;
    logic [ChanW-1:0] base_green;
    logic [ChanW-1:0] base_blue;
    logic [ChanW-1:0] base_alpha;
    logic [ChanW-1:0] mask_red;
    logic [ChanW-1:0] mask_green;
    logic [ChanW-1:0] mask_blue;
  } in_pix_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } out_pix_t;

  // White leaves a channel unchanged under the scale c * p / 255
  localparam logic [RgbW-1:0] TintWhite = 24'hFFFFFF;

  localparam logic [RgbW-1:0] TintRom [PaletteSize] = '{
    24'hFFFFFF, 24'hFFD4BF, 24'hFFE9BF, 24'hFFFFBF, 24'hE9FFBF, 24'hD4FFBF, 24'hBFFFBF,
    24'hBFFFD4, 24'hBFFFE9, 24'hBFFFFF, 24'hBFE9FF, 24'hBFD4FF, 24'hBFBFFF, 24'hD4BFFF,
    24'hE9BFFF, 24'hFFBFFF, 24'hFFBFE9, 24'hFFBFD4, 24'hFFBFBF, 24'hDADADA, 24'hBF9F8F,
    24'hBFAF8F, 24'hBFBF8F, 24'hAFBF8F, 24'h9FBF8F, 24'h8FBF8F, 24'h8FBF9F, 24'h8FBFAF,
    24'h8FBFBF, 24'h8FAFBF, 24'h8F9FBF, 24'h8F8FBF, 24'h9F8FBF, 24'hAF8FBF, 24'hBF8FBF,
    24'hBF8FAF, 24'hBF8F9F, 24'hBF8F8F, 24'hB6B6B6, 24'hBF7F5F, 24'hBFAF8F, 24'hBFBF5F,
    24'h9FBF5F, 24'h7FBF5F, 24'h5FBF5F, 24'h5FBF7F, 24'h5FBF9F, 24'h5FBFBF, 24'h5F9FBF,
    24'h5F7FBF, 24'h5F5FBF, 24'h7F5FBF, 24'h9F5FBF, 24'hBF5FBF, 24'hBF5F9F, 24'hBF5F7F,
    24'hBF5F5F, 24'h919191, 24'hBF6A3F, 24'hBF943F, 24'hBFBF3F, 24'h94BF3F, 24'h6ABF3F,
    24'h3FBF3F, 24'h3FBF6A, 24'h3FBF94, 24'h3FBFBF, 24'h3F94BF, 24'h3F6ABF, 24'h3F3FBF,
    24'h6A3FBF, 24'h943FBF, 24'hBF3FBF, 24'hBF3F94, 24'hBF3F6A, 24'hBF3F3F, 24'h6D6D6D,
    24'hFF5500, 24'hFFAA00, 24'hFFFF00, 24'hAAFF00, 24'h54FF00, 24'h00FF00, 24'h00FF54,
    24'h00FFAA, 24'h00FFFF, 24'h00A9FF, 24'h0055FF, 24'h0000FF, 24'h5500FF, 24'hA900FF,
    24'hFE00FF, 24'hFF00AA, 24'hFF0055, 24'hFF0000, 24'h484848, 24'hBF3F00, 24'hBF7F00,
    24'hBFBF00, 24'h7FBF00, 24'h3FBF00, 24'h00BF00, 24'h00BF3F, 24'h00BF7F, 24'h00BFBF,
    24'h007FBF, 24'h003FBF, 24'h0000BF, 24'h3F00BF, 24'h7F00BF, 24'hBF00BF, 24'hBF007F,
    24'hBF003F, 24'hBF0000, 24'h242424, 24'h7F2A00, 24'h7F5500, 24'h7F7F00, 24'h557F00,
    24'h2A7F00, 24'h007F00, 24'h007F2A, 24'h007F55, 24'h007F7F, 24'h00547F, 24'h002A7F,
    24'h00007F, 24'h2A007F, 24'h54007F, 24'h7F007F, 24'h7F0055, 24'h7F002A, 24'h7F0000
  };

  // Out-of-range indexes fall back to entry 0
  function automatic logic [RgbW-1:0] palette_lookup(logic [ChanW-1:0] idx);
    logic [RgbW-1:0] entry;
    entry = TintRom[0];
    if (idx < ChanW'(PaletteSize)) begin
      entry = TintRom[idx];
    end
    return entry;
  endfunction

  // Exact floor(c * p / 255) for 8-bit c and p, no divider
  function automatic logic [ChanW-1:0] scale_chan(logic [ChanW-1:0] c, logic [ChanW-1:0] p);
    logic [ProdW-1:0] prod;
    logic [ProdW:0]   sum;
    prod = ProdW'(c) * ProdW'(p);
    sum  = {1'b0, prod} + {{(ChanW+1){1'b0}}, prod[ProdW-1:ChanW]} + (ProdW+1)'(1);
    return sum[ProdW-1:ChanW];
  endfunction

endpackage

// ===== hw/rtl/mrpt_if.sv =====
interface mrpt_in_if;
  logic                  valid;
  logic                  ready;
  mrpt_pkg::in_pix_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrpt_out_if;
  logic                  valid;
  logic                  ready;
  mrpt_pkg::out_pix_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mask_region_palette_tint.sv =====
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    base RGBA pixel plus template mask RGB
// out_o     out  valid/ready    tinted RGB plus passed-through alpha
// cfg_*     in   write enable   four 8-bit palette indexes, no read-back
//
// One pixel per clock sustained while out_o.ready is high; two register
// stages (palette stage, then multiply and scale into the output register),
// and out_o.valid rises once an accepted pixel reaches the output register.
// rst_ni clears the stage valid bits and the four indexes to palette entry 0.
// A stalled output holds; the palette stage keeps taking transactions while
// it is empty, so in_i.ready drops only when both stages hold data and
// out_o.ready is low.
module mask_region_palette_tint (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mrpt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mrpt_pkg::ChanW-1:0]        cfg_wdata_i,
  mrpt_in_if.sink                           in_i,
  mrpt_out_if.source                        out_o
);

  // Region palette indexes
  logic [mrpt_pkg::ChanW-1:0] head_idx_q, body_idx_q, legs_idx_q, feet_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx_q <= '0;
      body_idx_q <= '0;
      legs_idx_q <= '0;
      feet_idx_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mrpt_pkg::cfg_reg_e'(cfg_idx_i))
        mrpt_pkg::CfgHeadIdx: head_idx_q <= cfg_wdata_i;
        mrpt_pkg::CfgBodyIdx: body_idx_q <= cfg_wdata_i;
        mrpt_pkg::CfgLegsIdx: legs_idx_q <= cfg_wdata_i;
        mrpt_pkg::CfgFeetIdx: feet_idx_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: each stage advances when it is empty or its successor takes
  logic s1_valid_q;
  logic out_valid_q;
  logic out_adv;
  logic s1_adv;

  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_i.ready = s1_adv;

  // Stage 1: region decode and palette fetch
  logic                       mask_r, mask_g, mask_b;
  mrpt_pkg::region_e          region;
  logic [mrpt_pkg::ChanW-1:0] region_idx;
  logic [mrpt_pkg::RgbW-1:0]  tint_d;

  assign mask_r = |in_i.data.mask_red;
  assign mask_g = |in_i.data.mask_green;
  assign mask_b = |in_i.data.mask_blue;

  always_comb begin
    case ({mask_r, mask_g, mask_b})
      3'b110:  region = mrpt_pkg::RegionHead;
      3'b100:  region = mrpt_pkg::RegionBody;
      3'b010:  region = mrpt_pkg::RegionLegs;
      3'b001:  region = mrpt_pkg::RegionFeet;
      default: region = mrpt_pkg::RegionNone;
    endcase
  end

  // Unselected pixels scale by white, which leaves them unchanged
  always_comb begin
    region_idx = '0;
    tint_d     = mrpt_pkg::TintWhite;
    unique case (region)
      mrpt_pkg::RegionHead: region_idx = head_idx_q;
      mrpt_pkg::RegionBody: region_idx = body_idx_q;
      mrpt_pkg::RegionLegs: region_idx = legs_idx_q;
      mrpt_pkg::RegionFeet: region_idx = feet_idx_q;
      default:              region_idx = '0;
    endcase
    if (region != mrpt_pkg::RegionNone) begin
      tint_d = mrpt_pkg::palette_lookup(region_idx);
    end
  end

  logic [mrpt_pkg::RgbW-1:0]  s1_tint_q;
  logic [mrpt_pkg::ChanW-1:0] s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload: load on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_i.valid) begin
      s1_tint_q  <= tint_d;
      s1_red_q   <= in_i.data.base_red;
      s1_green_q <= in_i.data.base_green;
      s1_blue_q  <= in_i.data.base_blue;
      s1_alpha_q <= in_i.data.base_alpha;
    end
  end

  // Stage 2: per-channel scale into the output register
  mrpt_pkg::out_pix_t out_d;
  mrpt_pkg::out_pix_t out_q;

  always_comb begin
    out_d.out_red   = mrpt_pkg::scale_chan(s1_red_q,   s1_tint_q[23:16]);
    out_d.out_green = mrpt_pkg::scale_chan(s1_green_q, s1_tint_q[15:8]);
    out_d.out_blue  = mrpt_pkg::scale_chan(s1_blue_q,  s1_tint_q[7:0]);
    out_d.out_alpha = s1_alpha_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
